// ----- rtl/gsos_pkg.sv -----
// Shared types, constants and lookup functions for the grouped sphere overlap scanner.
// Used by gsos_front, gsos_back and the top level; depends on nothing.
`default_nettype none
package gsos_pkg;

	localparam int MAX_SENSORS = 1024;
	localparam int SLOT_BITS   = $clog2(MAX_SENSORS);
	localparam int CNT_BITS    = SLOT_BITS + 1;
	localparam int COORD_BITS  = 24;
	localparam int RAD_BITS    = COORD_BITS - 1;
	localparam int HOST_BITS   = 16;
	localparam int NGROUPS     = 6;
	localparam int GRP_BITS    = 3;
	localparam int NSTAGES     = 14;
	localparam int STAGE_BITS  = 4;
	localparam int MEMB_DEPTH  = NGROUPS * MAX_SENSORS;
	localparam int MEMB_ABITS  = GRP_BITS + SLOT_BITS;
	localparam int DIFF_BITS   = COORD_BITS + 1;
	localparam int SQ_BITS     = 2 * DIFF_BITS;
	localparam int SUM_BITS    = SQ_BITS + 2;
	localparam int RSUM_BITS   = RAD_BITS + 1;
	localparam int RSQ_BITS    = 2 * RSUM_BITS;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_LOAD  = 2'd1;
	localparam logic [1:0] OP_SCAN  = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	localparam logic [GRP_BITS-1:0] G_PLAYER = 3'd0;
	localparam logic [GRP_BITS-1:0] G_RIDE   = 3'd1;
	localparam logic [GRP_BITS-1:0] G_EYE    = 3'd2;
	localparam logic [GRP_BITS-1:0] G_SIMPLE = 3'd3;
	localparam logic [GRP_BITS-1:0] G_MAPOBJ = 3'd4;
	localparam logic [GRP_BITS-1:0] G_CHAR   = 3'd5;

	localparam logic [7:0] TYPE_EYE = 8'h7A;
	localparam logic [7:0] TYPE_S0  = 8'h44;
	localparam logic [7:0] TYPE_S1  = 8'h46;
	localparam logic [7:0] TYPE_S2  = 8'h19;
	localparam logic [7:0] TYPE_S3  = 8'h41;
	localparam logic [7:0] TYPE_S4  = 8'h23;

	typedef struct packed {
		logic [1:0]            op;
		logic [GRP_BITS-1:0]   group;
		logic                  eye;
		logic                  active;
		logic [HOST_BITS-1:0]  host;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] z;
		logic [RAD_BITS-1:0]   radius;
	} cmd_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] z;
		logic [RAD_BITS-1:0]   radius;
		logic [HOST_BITS-1:0]  host;
		logic                  eye;
		logic                  active;
	} entry_t;

	// First group of each scan stage.
	function automatic logic [GRP_BITS-1:0] stage_a(input logic [STAGE_BITS-1:0] s);
		logic [GRP_BITS-1:0] g;
		unique case (s)
			4'd0, 4'd1, 4'd2, 4'd3, 4'd4: g = G_PLAYER;
			4'd5, 4'd6, 4'd7, 4'd8:        g = G_RIDE;
			4'd9, 4'd10, 4'd11:            g = G_EYE;
			default:                       g = G_CHAR;
		endcase
		return g;
	endfunction

	// Second group of each scan stage.
	function automatic logic [GRP_BITS-1:0] stage_b(input logic [STAGE_BITS-1:0] s);
		logic [GRP_BITS-1:0] g;
		unique case (s)
			4'd0, 4'd5, 4'd9, 4'd13: g = G_CHAR;
			4'd1, 4'd6, 4'd10, 4'd12: g = G_MAPOBJ;
			4'd2:                     g = G_RIDE;
			4'd3, 4'd7, 4'd11:        g = G_SIMPLE;
			default:                  g = G_EYE;
		endcase
		return g;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/gsos_front.sv -----
// Front end: accepts commands, classes loaded sensors into groups, and queues them.
// Depends on gsos_pkg.
`default_nettype none
module gsos_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cmd_valid,
	output logic                               cmd_stall,
	input  wire logic [1:0]                    opcode,
	input  wire logic [7:0]                    sensor_type,
	input  wire logic                          is_player,
	input  wire logic                          is_ride,
	input  wire logic                          is_rush,
	input  wire logic                          is_mapobj,
	input  wire logic                          active,
	input  wire logic [gsos_pkg::HOST_BITS-1:0] host_id,
	input  wire logic [gsos_pkg::COORD_BITS-1:0] pos_x,
	input  wire logic [gsos_pkg::COORD_BITS-1:0] pos_y,
	input  wire logic [gsos_pkg::COORD_BITS-1:0] pos_z,
	input  wire logic [gsos_pkg::RAD_BITS-1:0]  radius,
	output logic                               head_valid,
	output gsos_pkg::cmd_t                     head,
	input  wire logic                          pop
);
	gsos_pkg::cmd_t       fifo_q [2];
	logic                 wr_ptr_q, rd_ptr_q;
	logic [1:0]           cnt_q;
	gsos_pkg::cmd_t       cmd;
	logic                 push, is_simple;

	always_comb begin
		is_simple = (sensor_type == gsos_pkg::TYPE_S0) || (sensor_type == gsos_pkg::TYPE_S1) ||
			(sensor_type == gsos_pkg::TYPE_S2) || (sensor_type == gsos_pkg::TYPE_S3) ||
			(sensor_type == gsos_pkg::TYPE_S4) || is_rush;
		cmd.op     = opcode;
		cmd.eye    = (sensor_type == gsos_pkg::TYPE_EYE);
		cmd.active = active;
		cmd.host   = host_id;
		cmd.x      = pos_x;
		cmd.y      = pos_y;
		cmd.z      = pos_z;
		cmd.radius = radius;
		if (is_player) begin
			cmd.group = gsos_pkg::G_PLAYER;
		end else if (is_ride) begin
			cmd.group = gsos_pkg::G_RIDE;
		end else if (cmd.eye) begin
			cmd.group = gsos_pkg::G_EYE;
		end else if (is_simple) begin
			cmd.group = gsos_pkg::G_SIMPLE;
		end else if (is_mapobj) begin
			cmd.group = gsos_pkg::G_MAPOBJ;
		end else begin
			cmd.group = gsos_pkg::G_CHAR;
		end
	end

	assign cmd_stall  = (cnt_q == 2'd2);
	assign push       = cmd_valid && !cmd_stall;
	assign head_valid = (cnt_q != 2'd0);
	assign head       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

// ----- rtl/gsos_back.sv -----
// Back end: sensor store, group member lists, scan sequencer and overlap test.
// Depends on gsos_pkg; fed by gsos_front.
`default_nettype none
module gsos_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          head_valid,
	input  wire gsos_pkg::cmd_t                head,
	output logic                               pop,
	output logic                               res_valid,
	input  wire logic                          res_stall,
	output logic [1:0]                         status,
	output logic [gsos_pkg::SLOT_BITS-1:0]     first_slot,
	output logic [gsos_pkg::SLOT_BITS-1:0]     second_slot,
	output logic                               first_gets_hit,
	output logic                               second_gets_hit
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_STEP = 3'd1;
	localparam logic [2:0] S_RD1  = 3'd2;
	localparam logic [2:0] S_RD2  = 3'd3;
	localparam logic [2:0] S_MUL  = 3'd4;
	localparam logic [2:0] S_CMP  = 3'd5;

	localparam int SB = gsos_pkg::SLOT_BITS;
	localparam int CB = gsos_pkg::CNT_BITS;

	gsos_pkg::entry_t               store_mem [gsos_pkg::MAX_SENSORS];
	logic [SB-1:0]                  memb_mem  [gsos_pkg::MEMB_DEPTH];

	logic [2:0]                     state_q;
	logic [CB-1:0]                  gcount_q [gsos_pkg::NGROUPS];
	logic [CB-1:0]                  total_q;
	logic [gsos_pkg::STAGE_BITS-1:0] stage_q;
	logic [CB-1:0]                  outer_q, inner_q;

	logic [SB-1:0]                  memb_a_s1, memb_b_s1;
	logic [SB-1:0]                  sa_q, sb_q;
	gsos_pkg::entry_t               ent_a_s2, ent_b_s2;
	logic [gsos_pkg::DIFF_BITS-1:0] dx_s3, dy_s3, dz_s3;
	logic [gsos_pkg::RSUM_BITS-1:0] rs_s3;
	logic                           hit_ok_s3, eye_a_s3, eye_b_s3;
	logic [gsos_pkg::SQ_BITS-1:0]   sx_s4, sy_s4, sz_s4;
	logic [gsos_pkg::RSQ_BITS-1:0]  rsq_s4;
	logic                           hit_ok_s4, eye_a_s4, eye_b_s4;

	logic                           can_emit;
	logic                           emit;
	logic [gsos_pkg::GRP_BITS-1:0]  grp_a, grp_b;
	logic [CB-1:0]                  ca, cb;
	logic [gsos_pkg::SUM_BITS-1:0]  dist_sq;
	logic                           overlap;

	assign can_emit = !res_valid || !res_stall;
	assign grp_a    = gsos_pkg::stage_a(stage_q);
	assign grp_b    = gsos_pkg::stage_b(stage_q);
	assign ca       = gcount_q[grp_a];
	assign cb       = gcount_q[grp_b];
	assign pop      = (state_q == S_IDLE) && head_valid &&
		((head.op == gsos_pkg::OP_SCAN) || can_emit);

	// A result is written into the output register in this cycle.
	assign emit = ((state_q == S_IDLE) && pop && (head.op != gsos_pkg::OP_SCAN)) ||
		((state_q == S_STEP) && (stage_q >= gsos_pkg::STAGE_BITS'(gsos_pkg::NSTAGES)) &&
		can_emit) ||
		((state_q == S_CMP) && can_emit);

	assign dist_sq = {2'b00, sx_s4} + {2'b00, sy_s4} + {2'b00, sz_s4};
	assign overlap = dist_sq < {{(gsos_pkg::SUM_BITS-gsos_pkg::RSQ_BITS){1'b0}}, rsq_s4};

	function automatic logic [gsos_pkg::DIFF_BITS-1:0] abs_diff(
		input logic [gsos_pkg::COORD_BITS-1:0] a,
		input logic [gsos_pkg::COORD_BITS-1:0] b);
		logic signed [gsos_pkg::DIFF_BITS-1:0] d;
		d = $signed({a[gsos_pkg::COORD_BITS-1], a}) - $signed({b[gsos_pkg::COORD_BITS-1], b});
		return d[gsos_pkg::DIFF_BITS-1] ? (~d + 1'b1) : d;
	endfunction

	// Load writes and pipelined reads of both memories.
	always_ff @(posedge clk) begin
		if (pop && (head.op == gsos_pkg::OP_LOAD) && !total_q[CB-1]) begin
			store_mem[total_q[SB-1:0]] <= '{x: head.x, y: head.y, z: head.z,
				radius: head.radius, host: head.host, eye: head.eye, active: head.active};
			memb_mem[{head.group, gcount_q[head.group][SB-1:0]}] <= total_q[SB-1:0];
		end
		memb_a_s1 <= memb_mem[{grp_a, outer_q[SB-1:0]}];
		memb_b_s1 <= memb_mem[{grp_b, inner_q[SB-1:0]}];
		ent_a_s2  <= store_mem[memb_a_s1];
		ent_b_s2  <= store_mem[memb_b_s1];
	end

	// Datapath stages of the overlap test.
	always_ff @(posedge clk) begin
		if (state_q == S_RD1) begin
			sa_q <= memb_a_s1;
			sb_q <= memb_b_s1;
		end
		if (state_q == S_RD2) begin
			dx_s3     <= abs_diff(ent_a_s2.x, ent_b_s2.x);
			dy_s3     <= abs_diff(ent_a_s2.y, ent_b_s2.y);
			dz_s3     <= abs_diff(ent_a_s2.z, ent_b_s2.z);
			rs_s3     <= {1'b0, ent_a_s2.radius} + {1'b0, ent_b_s2.radius};
			hit_ok_s3 <= ent_a_s2.active && ent_b_s2.active && (ent_a_s2.host != ent_b_s2.host);
			eye_a_s3  <= ent_a_s2.eye;
			eye_b_s3  <= ent_b_s2.eye;
		end
		if (state_q == S_MUL) begin
			sx_s4     <= dx_s3 * dx_s3;
			sy_s4     <= dy_s3 * dy_s3;
			sz_s4     <= dz_s3 * dz_s3;
			rsq_s4    <= rs_s3 * rs_s3;
			hit_ok_s4 <= hit_ok_s3;
			eye_a_s4  <= eye_a_s3;
			eye_b_s4  <= eye_b_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			total_q         <= '0;
			stage_q         <= '0;
			outer_q         <= '0;
			inner_q         <= '0;
			gcount_q        <= '{default: '0};
			res_valid       <= 1'b0;
			status          <= gsos_pkg::ST_OK;
			first_slot      <= '0;
			second_slot     <= '0;
			first_gets_hit  <= 1'b0;
			second_gets_hit <= 1'b0;
		end else begin
			res_valid <= emit || (res_valid && res_stall);
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						if (head.op == gsos_pkg::OP_SCAN) begin
							state_q <= S_STEP;
						end else begin
							status          <= gsos_pkg::ST_OK;
							first_slot      <= '0;
							second_slot     <= '0;
							first_gets_hit  <= 1'b0;
							second_gets_hit <= 1'b0;
							if (head.op == gsos_pkg::OP_CLEAR) begin
								total_q  <= '0;
								stage_q  <= '0;
								outer_q  <= '0;
								inner_q  <= '0;
								gcount_q <= '{default: '0};
							end else if (head.op == gsos_pkg::OP_LOAD) begin
								if (total_q[CB-1]) begin
									status <= gsos_pkg::ST_FULL;
								end else begin
									first_slot <= total_q[SB-1:0];
									total_q    <= total_q + 1'b1;
									gcount_q[head.group] <= gcount_q[head.group] + 1'b1;
								end
							end
						end
					end
				end
				S_STEP: begin
					if (stage_q >= gsos_pkg::STAGE_BITS'(gsos_pkg::NSTAGES)) begin
						if (can_emit) begin
							stage_q         <= '0;
							outer_q         <= '0;
							inner_q         <= '0;
							status          <= gsos_pkg::ST_DONE;
							first_slot      <= '0;
							second_slot     <= '0;
							first_gets_hit  <= 1'b0;
							second_gets_hit <= 1'b0;
							state_q         <= S_IDLE;
						end
					end else if ((outer_q >= ca) || (cb == '0)) begin
						stage_q <= stage_q + 1'b1;
						outer_q <= '0;
						inner_q <= '0;
					end else if (inner_q >= cb) begin
						outer_q <= outer_q + 1'b1;
						inner_q <= (stage_q == gsos_pkg::STAGE_BITS'(gsos_pkg::NSTAGES - 1)) ?
							outer_q + 1'b1 : '0;
					end else begin
						// Member read addresses are taken at this edge.
						inner_q <= inner_q + 1'b1;
						state_q <= S_RD1;
					end
				end
				S_RD1: state_q <= S_RD2;
				S_RD2: state_q <= S_MUL;
				S_MUL: state_q <= S_CMP;
				S_CMP: begin
					if (can_emit) begin
						status          <= gsos_pkg::ST_OK;
						first_slot      <= sa_q;
						second_slot     <= sb_q;
						first_gets_hit  <= hit_ok_s4 && overlap && !eye_b_s4;
						second_gets_hit <= hit_ok_s4 && overlap && !eye_a_s4;
						state_q         <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/grouped_sphere_overlap_scanner_unit.sv -----
// Top level of the grouped sphere overlap scanner: front end, queue and back end.
// Depends on gsos_pkg, gsos_front and gsos_back.
`default_nettype none
// Every accepted command gives exactly one result transfer. A clear or a load is handled
// in the back end once the output register is free. A scan tick first walks the pair
// sequencer one step per cycle (a step skips an empty group pair or advances the outer
// index; the step that ends the scan waits for a free output register), then takes the
// tested pair through a member list read, a sensor store read, the coordinate
// differences, the squares, and the final sum and compare. A two-entry queue between
// the front and back lets commands be taken while a result is still waiting. Memories
// need no clearing after reset; only slots already loaded are ever used in a result.
module grouped_sphere_overlap_scanner_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cmd_valid,
	output logic                                cmd_stall,
	input  wire logic [1:0]                     opcode,
	input  wire logic [7:0]                     sensor_type,
	input  wire logic                           is_player,
	input  wire logic                           is_ride,
	input  wire logic                           is_rush,
	input  wire logic                           is_mapobj,
	input  wire logic                           active,
	input  wire logic [gsos_pkg::HOST_BITS-1:0]  host_id,
	input  wire logic [gsos_pkg::COORD_BITS-1:0] pos_x,
	input  wire logic [gsos_pkg::COORD_BITS-1:0] pos_y,
	input  wire logic [gsos_pkg::COORD_BITS-1:0] pos_z,
	input  wire logic [gsos_pkg::RAD_BITS-1:0]   radius,
	output logic                                res_valid,
	input  wire logic                           res_stall,
	output logic [1:0]                          status,
	output logic [gsos_pkg::SLOT_BITS-1:0]      first_slot,
	output logic [gsos_pkg::SLOT_BITS-1:0]      second_slot,
	output logic                                first_gets_hit,
	output logic                                second_gets_hit
);
	logic           head_valid;
	gsos_pkg::cmd_t head;
	logic           pop;

	// The front end classes each sensor and queues the command.
	gsos_front u_front (
		.clk, .arst_n, .cmd_valid, .cmd_stall, .opcode, .sensor_type,
		.is_player, .is_ride, .is_rush, .is_mapobj, .active, .host_id,
		.pos_x, .pos_y, .pos_z, .radius, .head_valid, .head, .pop
	);

	// The back end holds the store and runs the scan.
	gsos_back u_back (
		.clk, .arst_n, .head_valid, .head, .pop, .res_valid, .res_stall,
		.status, .first_slot, .second_slot, .first_gets_hit, .second_gets_hit
	);
endmodule
`default_nettype wire
